[rtl/core/smap_pkg.sv]
// ----------------------------------------------------------------------------
// smap_pkg
// Types and constants shared by the serial bank mapper modules.
// ----------------------------------------------------------------------------
`default_nettype none

package smap_pkg;

  // Width of the serial register and of its beat counter.
  localparam int SHIFT_BITS = 5;
  localparam int SHIFT_CNT_W = 3;
  // Width of the bank count registers.
  localparam int COUNT_W = 5;
  // Data bit that clears the serial register.
  localparam int RESET_BIT = 7;
  // A 16 kB bank spans this many address bits.
  localparam int BANK_OFS_W = 14;

  typedef struct packed {
    logic        operation;
    logic [14:0] address;
    logic [7:0]  data;
  } in_item_t;

  typedef struct packed {
    logic [17:0] prg_offset;
    logic        no_rom;
    logic [1:0]  mirror_mode;
    logic [4:0]  chr_low_window;
    logic [4:0]  chr_high_window;
  } out_item_t;

  typedef enum logic {
    CFG_PRG_BANK_COUNT = 1'b0,
    CFG_CHR_BANK_COUNT = 1'b1
  } cfg_index_t;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    SEL_CONTROL  = 2'd0,
    SEL_CHR_LOW  = 2'd1,
    SEL_CHR_HIGH = 2'd2,
    SEL_PRG      = 2'd3
  } reg_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic commit;
  } smap_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_div;
    logic div_last;
  } smap_status_t;

endpackage

`default_nettype wire

[rtl/core/smap_ctrl.sv]
// ----------------------------------------------------------------------------
// smap_ctrl
// Sequencer: takes one beat, runs the remainder unit when a bank write
// needs it, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module smap_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire smap_pkg::smap_status_t st,
  output smap_pkg::smap_cmd_t       cmd
);
  import smap_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    cmd.load     = in_valid && (state_r == ST_IDLE);
    cmd.div_init = cmd.load && st.needs_div;
    cmd.div_step = (state_r == ST_DIV);
    cmd.commit   = (state_r == ST_DONE) && (!out_valid_r || out_ready);
    case (state_r)
      ST_IDLE: begin
        if (cmd.load) begin
          state_nxt = st.needs_div ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (st.div_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (cmd.commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_div_ends : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && st.div_last) |=> (state_r == ST_DONE))
    else $error("remainder unit did not hand over to the result stage");

  a_plain_beat : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && !st.needs_div) |=> (state_r == ST_DONE))
    else $error("beat without a bank reduction entered the remainder unit");

  a_commit_shows : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");
`endif

endmodule

`default_nettype wire

[rtl/core/smap_dp.sv]
// ----------------------------------------------------------------------------
// smap_dp
// Mapper state, serial register, bit-serial remainder unit, read address
// translation and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module smap_dp #(
  parameter int MAX_PRG_BANKS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire smap_pkg::cfg_index_t cfg_index,
  input  wire logic [4:0]           cfg_wdata,
  input  wire smap_pkg::in_item_t   in_data,
  input  wire smap_pkg::smap_cmd_t  cmd,
  output smap_pkg::smap_status_t    st,
  output smap_pkg::out_item_t       out_data
);
  import smap_pkg::*;

  localparam logic [COUNT_W-1:0] MaxPrg = COUNT_W'(MAX_PRG_BANKS);

  // Configuration
  logic [COUNT_W-1:0] prg_cnt_r, chr_cnt_r;
  logic [COUNT_W-1:0] pc_eff;

  // Mapper state
  logic [SHIFT_BITS-1:0]  sv_r, sv_nxt;
  logic [SHIFT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                   fix_r, fix_nxt;
  logic                   b16_r, b16_nxt;
  logic                   chr4_r, chr4_nxt;
  logic [1:0]             mirror_r, mirror_nxt;
  logic [3:0]             prg_r, prg_nxt;
  logic [4:0]             chr_lo_r, chr_lo_nxt;
  logic [4:0]             chr_hi_r, chr_hi_nxt;

  // Held beat and remainder unit
  in_item_t               item_r;
  logic [SHIFT_BITS:0]    div_d_r;
  logic [SHIFT_BITS-1:0]  div_n_r;
  logic [SHIFT_BITS-1:0]  rem_r;
  logic [SHIFT_CNT_W-1:0] bit_r;
  logic [SHIFT_BITS:0]    trial;

  // Decode of the incoming beat
  logic [SHIFT_BITS-1:0]  in_shift;
  logic                   in_commit;
  reg_sel_t               in_sel;

  logic [SHIFT_BITS-1:0]  it_shift;
  logic                   it_commit;
  reg_sel_t               it_sel;

  logic [3:0]             rd_bank;
  out_item_t              res;
  out_item_t              out_data_r;

  assign pc_eff = (prg_cnt_r > MaxPrg) ? MaxPrg : prg_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_cnt_r <= '0;
      chr_cnt_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PRG_BANK_COUNT: prg_cnt_r <= cfg_wdata;
        CFG_CHR_BANK_COUNT: chr_cnt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The state is stable while a beat waits, so the reduction can be set up
  // from the incoming beat directly.
  assign in_shift  = {in_data.data[0], sv_r[SHIFT_BITS-1:1]};
  assign in_sel    = reg_sel_t'(in_data.address[14:13]);
  assign in_commit = (in_data.operation == OP_WRITE) && !in_data.data[RESET_BIT]
                     && (cnt_r == SHIFT_CNT_W'(SHIFT_BITS - 1));

  always_comb begin
    st           = '0;
    st.div_last  = (bit_r == '0);
    st.needs_div = in_commit &&
                   (((in_sel == SEL_CHR_LOW || in_sel == SEL_CHR_HIGH)
                     && chr_cnt_r != '0)
                    || (in_sel == SEL_PRG && pc_eff != '0));
  end

  // Restoring remainder, one dividend bit a cycle from the top.
  assign trial = {rem_r, div_n_r[bit_r]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.div_init) begin
      rem_r <= '0;
      bit_r <= SHIFT_CNT_W'(SHIFT_BITS - 1);
      if (in_sel == SEL_PRG) begin
        div_d_r <= {1'b0, pc_eff};
        div_n_r <= {1'b0, in_shift[3:0]};
      end else begin
        div_d_r <= {chr_cnt_r, 1'b0};
        div_n_r <= in_shift;
      end
    end else if (cmd.div_step) begin
      rem_r <= (trial >= div_d_r) ? SHIFT_BITS'(trial - div_d_r)
                                  : trial[SHIFT_BITS-1:0];
      bit_r <= bit_r - 1'b1;
    end
  end

  assign it_shift  = {item_r.data[0], sv_r[SHIFT_BITS-1:1]};
  assign it_sel    = reg_sel_t'(item_r.address[14:13]);
  assign it_commit = (item_r.operation == OP_WRITE) && !item_r.data[RESET_BIT]
                     && (cnt_r == SHIFT_CNT_W'(SHIFT_BITS - 1));

  always_comb begin
    sv_nxt     = sv_r;
    cnt_nxt    = cnt_r;
    fix_nxt    = fix_r;
    b16_nxt    = b16_r;
    chr4_nxt   = chr4_r;
    mirror_nxt = mirror_r;
    prg_nxt    = prg_r;
    chr_lo_nxt = chr_lo_r;
    chr_hi_nxt = chr_hi_r;
    if (item_r.operation == OP_WRITE) begin
      if (item_r.data[RESET_BIT]) begin
        fix_nxt = 1'b1;
        b16_nxt = 1'b1;
        sv_nxt  = '0;
        cnt_nxt = '0;
      end else if (it_commit) begin
        sv_nxt  = '0;
        cnt_nxt = '0;
        case (it_sel)
          SEL_CONTROL: begin
            mirror_nxt = it_shift[1:0];
            fix_nxt    = it_shift[2];
            b16_nxt    = it_shift[3];
            chr4_nxt   = it_shift[4];
          end
          SEL_CHR_LOW: begin
            if (chr_cnt_r != '0) begin
              chr_lo_nxt = rem_r;
            end
          end
          SEL_CHR_HIGH: begin
            if (chr_cnt_r != '0) begin
              chr_hi_nxt = rem_r;
            end
          end
          SEL_PRG: begin
            prg_nxt = (pc_eff != '0) ? rem_r[3:0] : 4'd0;
          end
          default: ;
        endcase
      end else begin
        sv_nxt  = it_shift;
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  // Read translation; the last bank is the effective count less one.
  always_comb begin
    if (item_r.address[BANK_OFS_W] == 1'b0) begin
      rd_bank = fix_r ? prg_r : 4'd0;
    end else begin
      rd_bank = fix_r ? 4'(pc_eff - 1'b1) : prg_r;
    end
  end

  always_comb begin
    res                 = '0;
    res.mirror_mode     = mirror_nxt;
    res.chr_low_window  = chr4_nxt ? chr_lo_nxt : {chr_lo_nxt[4:1], 1'b0};
    res.chr_high_window = chr4_nxt ? chr_hi_nxt : {chr_lo_nxt[4:1], 1'b1};
    if (item_r.operation == OP_READ) begin
      if (pc_eff == '0) begin
        res.no_rom = 1'b1;
      end else if (!b16_r) begin
        res.prg_offset = {prg_r[3:1], item_r.address};
      end else begin
        res.prg_offset = {rd_bank, item_r.address[BANK_OFS_W-1:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r     <= '0;
      cnt_r    <= '0;
      fix_r    <= 1'b1;
      b16_r    <= 1'b1;
      chr4_r   <= 1'b0;
      mirror_r <= '0;
      prg_r    <= '0;
      chr_lo_r <= '0;
      chr_hi_r <= '0;
    end else if (cmd.commit) begin
      sv_r     <= sv_nxt;
      cnt_r    <= cnt_nxt;
      fix_r    <= fix_nxt;
      b16_r    <= b16_nxt;
      chr4_r   <= chr4_nxt;
      mirror_r <= mirror_nxt;
      prg_r    <= prg_nxt;
      chr_lo_r <= chr_lo_nxt;
      chr_hi_r <= chr_hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= res;
    end
  end

  assign out_data = out_data_r;

`ifndef SYNTH
  a_cnt_range : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < SHIFT_CNT_W'(SHIFT_BITS))
    else $error("serial register beat count ran past the commit point");

  a_init_state : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_init |=> (rem_r == '0 && div_d_r != '0))
    else $error("remainder unit started with a zero divisor");
`endif

endmodule

`default_nettype wire

[rtl/core/serial_bank_mapper.sv]
// ----------------------------------------------------------------------------
// serial_bank_mapper
// Cartridge bank mapper with a five-write serial register interface.
//
//   Port group  Direction  Handshake          Beat contents
//   in_*        input      in_valid/in_ready  operation, address, data
//   out_*       output     out_valid/out_ready prg_offset, no_rom, mirror,
//                                              CHR windows
//   cfg_*       input      cfg_wr_en          bank count register write
//
// A read, or a write that needs no bank reduction, goes from the held beat
// register to the output register; a fifth write to a CHR or PRG bank
// register with a non-zero bank count first runs through the bit-serial
// remainder unit. One beat is in flight at a time; the next is
// taken once the previous result sits in the output register, even if it
// is not yet consumed. Reset is synchronous and active low, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_bank_mapper #(
  parameter int MAX_PRG_BANKS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire smap_pkg::cfg_index_t cfg_index,
  input  wire logic [4:0]           cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire smap_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output smap_pkg::out_item_t       out_data
);
  import smap_pkg::*;

  smap_cmd_t    cmd;
  smap_status_t st;

  smap_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  smap_dp #(
    .MAX_PRG_BANKS (MAX_PRG_BANKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
